### rtl/esc_pkg.sv
// Shared types and constants for the epoch-seconds-to-calendar-date unit.
// Used by the controller, the datapath and the top level; no dependencies.
package esc_pkg;

  // seconds / 86400 taken as (seconds >> 7) / 675, exact for 25-bit operands
  localparam logic [25:0] RecipDay     = 26'd50903317;   // ceil(2^35 / 675)
  localparam int unsigned ShiftDay     = 35;
  localparam logic [16:0] SecsPerDay   = 17'd86400;
  localparam logic [15:0] DaysToEpoch  = 16'd731;   // 1968-01-01 .. 1970-01-01

  // days / 1461, exact for 16-bit operands
  localparam logic [16:0] RecipCycle   = 17'd91868;      // ceil(2^27 / 1461)
  localparam int unsigned ShiftCycle   = 27;
  localparam logic [10:0] DaysPerCycle = 11'd1461;

  // first day of each of the later, non-leap years of a leap-year group
  localparam logic [10:0] DaysYear1    = 11'd366;
  localparam logic [10:0] DaysYear2    = 11'd731;
  localparam logic [10:0] DaysYear3    = 11'd1096;

  // seconds-of-day / 3600 taken as (s >> 4) / 225
  localparam logic [13:0] RecipHour    = 14'd9321;       // ceil(2^21 / 225)
  localparam int unsigned ShiftHour    = 21;
  localparam logic [11:0] SecsPerHour  = 12'd3600;

  // seconds-of-hour / 60 taken as (s >> 2) / 15
  localparam logic [10:0] RecipMin     = 11'd1093;       // ceil(2^14 / 15)
  localparam int unsigned ShiftMin     = 14;
  localparam logic [5:0]  SecsPerMin   = 6'd60;

  localparam logic [11:0] BaseYear     = 12'd1968;
  localparam logic [31:0] LimitSeconds = 32'd4102444800;

  localparam logic [3:0] MonthFeb = 4'd1;
  localparam logic [3:0] MonthDec = 4'd11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_SOD,
    S_CYCLE,
    S_SPLIT,
    S_YEAR,
    S_SEC,
    S_WALK
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,      // capture the word and the range flag
    OP_DAY,        // day count by reciprocal multiply
    OP_SOD,        // seconds of day, rebase days to 1968
    OP_CYCLE,      // four-year cycle count and hour
    OP_SPLIT,      // day within cycle, cycle year, seconds of hour
    OP_YEAR,       // year within cycle, day of year, minute
    OP_WALK_INIT,  // second, clear month
    OP_WALK        // subtract one month length
  } op_e;

  typedef struct packed {
    op_e op;
  } esc_cmd_t;

  typedef struct packed {
    logic walk_done;
  } esc_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      MonthFeb:                                 len = leap ? 5'd29 : 5'd28;
      default:                                  len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

### rtl/esc_ctrl.sv
// Sequencer for the calendar conversion: steps the datapath through the
// fixed arithmetic passes and the month walk. Depends on esc_pkg.
module esc_ctrl import esc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  esc_sts_t sts_i,
  output esc_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_START;
          state_d  = S_DAY;
        end
      end
      S_DAY: begin
        cmd_o.op = OP_DAY;
        state_d  = S_SOD;
      end
      S_SOD: begin
        cmd_o.op = OP_SOD;
        state_d  = S_CYCLE;
      end
      S_CYCLE: begin
        cmd_o.op = OP_CYCLE;
        state_d  = S_SPLIT;
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT;
        state_d  = S_YEAR;
      end
      S_YEAR: begin
        cmd_o.op = OP_YEAR;
        state_d  = S_SEC;
      end
      S_SEC: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          cmd_o.op = OP_WALK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_WALK) && state_q == S_IDLE)
    else $error("result strobe without finished month walk");

  a_start_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_DAY)
    else $error("accepted word did not launch the day division");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |-> cmd_o.op == OP_NONE)
    else $error("datapath command issued while idle");

  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !sts_i.walk_done) |=> state_q == S_WALK)
    else $error("month walk left early");
`endif

endmodule

### rtl/esc_datapath.sv
// Datapath: reciprocal-multiply constant divisions, year/day bookkeeping,
// month walk and result registers. Driven by esc_ctrl; depends on esc_pkg.
module esc_datapath import esc_pkg::*; (
  input  logic        clk_i,
  input  esc_cmd_t    cmd_i,
  input  logic [31:0] utc_seconds_i,
  output esc_sts_t    sts_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_of_year_o,
  output logic [11:0] calendar_year_o,
  output logic        out_of_range_o
);

  // intermediate state
  logic [31:0] t_q;
  logic [15:0] days_q;
  logic [15:0] ep_days_q;
  logic [16:0] sod_q;
  logic [5:0]  cyc_q;
  logic [10:0] cyc_day_q;
  logic [11:0] rsec_q;
  // calendar state
  logic [11:0] year_q;
  logic [10:0] day_q;
  logic        leap_q;
  logic [3:0]  mon_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic        oor_q;

  logic [50:0] day_prod;
  logic [16:0] day_secs;
  logic [32:0] cyc_prod;
  logic [26:0] hour_prod;
  logic [10:0] cyc_days;
  logic [11:0] hour_secs;
  logic [20:0] min_prod;
  logic [5:0]  min_secs;
  logic [4:0]  mlen;

  assign day_prod  = {26'd0, t_q[31:7]} * {25'd0, RecipDay};
  // remainders only need the low bits: each true result fits its width
  assign day_secs  = {1'b0, days_q} * SecsPerDay;
  assign cyc_prod  = {17'd0, ep_days_q} * {16'd0, RecipCycle};
  assign hour_prod = {14'd0, sod_q[16:4]} * {13'd0, RecipHour};
  assign cyc_days  = {5'd0, cyc_q} * DaysPerCycle;
  assign hour_secs = {7'd0, hour_q} * SecsPerHour;
  assign min_prod  = {11'd0, rsec_q[11:2]} * {10'd0, RecipMin};
  assign min_secs  = min_q * SecsPerMin;

  assign mlen            = month_len(mon_q, leap_q);
  assign sts_o.walk_done = (day_q < 11'(mlen)) || (mon_q == MonthDec);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        t_q   <= utc_seconds_i;
        oor_q <= (utc_seconds_i >= LimitSeconds);
      end
      OP_DAY: begin
        days_q <= day_prod[ShiftDay+15:ShiftDay];
      end
      OP_SOD: begin
        sod_q     <= t_q[16:0] - day_secs;
        ep_days_q <= days_q + DaysToEpoch;
      end
      OP_CYCLE: begin
        cyc_q  <= cyc_prod[ShiftCycle+5:ShiftCycle];
        hour_q <= hour_prod[ShiftHour+4:ShiftHour];
      end
      OP_SPLIT: begin
        cyc_day_q <= ep_days_q[10:0] - cyc_days;
        year_q    <= BaseYear + {4'd0, cyc_q, 2'b00};
        rsec_q    <= sod_q[11:0] - hour_secs;
      end
      OP_YEAR: begin
        min_q <= min_prod[ShiftMin+5:ShiftMin];
        // first year of the cycle is the leap year
        if (cyc_day_q >= DaysYear3) begin
          leap_q <= 1'b0;
          year_q <= year_q + 12'd3;
          day_q  <= cyc_day_q - DaysYear3;
        end else if (cyc_day_q >= DaysYear2) begin
          leap_q <= 1'b0;
          year_q <= year_q + 12'd2;
          day_q  <= cyc_day_q - DaysYear2;
        end else if (cyc_day_q >= DaysYear1) begin
          leap_q <= 1'b0;
          year_q <= year_q + 12'd1;
          day_q  <= cyc_day_q - DaysYear1;
        end else begin
          leap_q <= 1'b1;
          day_q  <= cyc_day_q;
        end
      end
      OP_WALK_INIT: begin
        sec_q <= rsec_q[5:0] - min_secs;
        mon_q <= '0;
      end
      OP_WALK: begin
        if (!sts_o.walk_done) begin
          day_q <= day_q - 11'(mlen);
          mon_q <= mon_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign day_of_month_o     = day_q[4:0] + 5'd1;
  assign month_of_year_o    = mon_q + 4'd1;
  assign calendar_year_o    = year_q;
  assign out_of_range_o     = oor_q;

endmodule

### rtl/epoch_seconds_to_calendar_date_unit.sv
// Top level of the epoch-seconds-to-calendar-date unit: controller plus
// datapath. Depends on esc_pkg, esc_ctrl and esc_datapath.
//
// Usage:
//   Drive utc_seconds_i and raise start_i; the word is taken at a rising
//   edge where start_i is high and busy_o is low. busy_o stays high while
//   the conversion runs. The result (second, minute, hour, day, month,
//   year, out_of_range) appears on the result ports for one cycle with
//   done_o high; the outputs keep that value until the next word starts.
//   The time from the accepting edge to the done_o cycle grows with the
//   month number (1..12) of the result. One word is in flight at a time;
//   a new start_i is taken in the done_o cycle. The conversion runs six
//   fixed steps (constant divisions done as reciprocal multiplies, their
//   remainders and the year split) followed by a month walk of one month
//   per cycle.
//   Reset (rst_ni low, asynchronous) returns the controller to idle and
//   drops busy_o and done_o; result ports are undefined until the first
//   result. The receiver cannot stall: done_o is a single-cycle strobe.
module epoch_seconds_to_calendar_date_unit import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] utc_seconds_i,
  output logic        done_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_of_year_o,
  output logic [11:0] calendar_year_o,
  output logic        out_of_range_o
);

  esc_cmd_t cmd;
  esc_sts_t sts;

  esc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  esc_datapath u_dp (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .utc_seconds_i      (utc_seconds_i),
    .sts_o              (sts),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .day_of_month_o     (day_of_month_o),
    .month_of_year_o    (month_of_year_o),
    .calendar_year_o    (calendar_year_o),
    .out_of_range_o     (out_of_range_o)
  );

endmodule

### bench/calendar_date_checker.sv
// Checker for the epoch-seconds-to-calendar-date unit: watches the start/busy
// and done channels, predicts each date and compares it field by field.
// Stand-alone; needs no package.
module calendar_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] utc_seconds_i,
  input  logic        done_i,
  input  logic [5:0]  second_of_minute_i,
  input  logic [5:0]  minute_of_hour_i,
  input  logic [4:0]  hour_of_day_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [3:0]  month_of_year_i,
  input  logic [11:0] calendar_year_i,
  input  logic        out_of_range_i,
  output int          mismatch_count_o,
  output int          dates_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
    logic        late;
  } cal_date_t;

  localparam int unsigned DaySeconds  = 86400;
  localparam int unsigned LeadDays    = 731;    // 1968-01-01 .. 1970-01-01
  localparam int unsigned QuadDays    = 1461;
  localparam int unsigned EpochYear   = 1968;
  localparam int unsigned LastSecond  = 32'd4102444800;

  cal_date_t expected_dates [$];
  int        mismatches;
  int        pending;

  assign mismatch_count_o = mismatches;
  assign dates_pending_o  = pending;

  function automatic cal_date_t date_of_seconds(input logic [31:0] t);
    int unsigned mlen [12];
    int unsigned sod;
    int unsigned days;
    int unsigned yr;
    int unsigned d;
    int unsigned m;
    int unsigned len;
    bit          leap;
    cal_date_t   r;
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    sod  = t % DaySeconds;
    days = t / DaySeconds + LeadDays;
    yr   = EpochYear + 4 * (days / QuadDays);
    d    = days % QuadDays;
    if (d < 366) begin
      leap = 1'b1;
    end else begin
      d    = d - 366;
      yr   = yr + 1 + d / 365;
      d    = d % 365;
      leap = 1'b0;
    end
    m = 0;
    forever begin
      len = (m == 1 && leap) ? 29 : mlen[m];
      if (d < len || m == 11) break;
      d = d - len;
      m++;
    end
    r.sec   = 6'(sod % 60);
    r.min   = 6'((sod / 60) % 60);
    r.hour  = 5'(sod / 3600);
    r.mday  = 5'(d + 1);
    r.month = 4'(m + 1);
    r.year  = 12'(yr);
    r.late  = (t >= LastSecond);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk_i) begin
    cal_date_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_dates.size() == 0) begin
          $error("done strobe with no word outstanding");
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          pending--;
          compare_field("second_of_minute", want.sec,   second_of_minute_i);
          compare_field("minute_of_hour",   want.min,   minute_of_hour_i);
          compare_field("hour_of_day",      want.hour,  hour_of_day_i);
          compare_field("day_of_month",     want.mday,  day_of_month_i);
          compare_field("month_of_year",    want.month, month_of_year_i);
          compare_field("calendar_year",    want.year,  calendar_year_i);
          compare_field("out_of_range",     want.late,  out_of_range_i);
        end
      end
      if (start_i && !busy_i) begin
        expected_dates.push_back(date_of_seconds(utc_seconds_i));
        pending++;
      end
    end
  end

endmodule

### bench/tb_top.sv
// Testbench top for epoch_seconds_to_calendar_date_unit: clock, reset,
// directed and random timestamps, verdict. Depends on esc_pkg and the checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int unsigned WordsPerPhase = 450;
  localparam int unsigned DrainCycles   = 250;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] utc_seconds_i;
  logic        done_o;
  logic [5:0]  second_of_minute_o;
  logic [5:0]  minute_of_hour_o;
  logic [4:0]  hour_of_day_o;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_of_year_o;
  logic [11:0] calendar_year_o;
  logic        out_of_range_o;
  int          mismatch_count;
  int          dates_pending;

  epoch_seconds_to_calendar_date_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .utc_seconds_i      (utc_seconds_i),
    .done_o             (done_o),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .day_of_month_o     (day_of_month_o),
    .month_of_year_o    (month_of_year_o),
    .calendar_year_o    (calendar_year_o),
    .out_of_range_o     (out_of_range_o)
  );

  calendar_date_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .utc_seconds_i      (utc_seconds_i),
    .done_i             (done_o),
    .second_of_minute_i (second_of_minute_o),
    .minute_of_hour_i   (minute_of_hour_o),
    .hour_of_day_i      (hour_of_day_o),
    .day_of_month_i     (day_of_month_o),
    .month_of_year_i    (month_of_year_o),
    .calendar_year_i    (calendar_year_o),
    .out_of_range_i     (out_of_range_o),
    .mismatch_count_o   (mismatch_count),
    .dates_pending_o    (dates_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [31:0] secs);
    bit taken;
    start_i       <= 1'b1;
    utc_seconds_i <= secs;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (dates_pending != 0) @(negedge clk_i);
  endtask

  // Mix of raw words, in-range words and instants on day boundaries or at random within a day.
  function automatic logic [31:0] pick_seconds();
    longint unsigned v;
    int unsigned     sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = $urandom;
    end else if (sel < 60) begin
      v = $urandom_range(LimitSeconds - 1);
    end else begin
      v = longint'($urandom_range(49710)) * 86400;
      case ($urandom_range(2))
        0: v = v + 86399;
        1: v = v + $urandom_range(86399);
        default: ;
      endcase
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  initial begin
    logic [31:0] directed [] = '{
      32'd0,                    // epoch start
      32'hFFFF_FFFF,            // largest word, year 2106
      32'd31535999,             // 1970-12-31 23:59:59
      32'd31536000,             // 1971-01-01
      32'd68083199,             // 1972-02-27 23:59:59
      32'd68169600,             // 1972-02-29, leap day at cycle start
      32'd68256000,             // 1972-03-01
      32'd94694399,             // last second of a leap year
      32'd99791999,             // 1973-02-28 23:59:59
      32'd99792000,             // 1973-03-01, no leap day
      32'd951782400,            // 2000-02-29
      32'h7FFF_FFFF,
      32'h8000_0000,
      32'h5555_5555,
      32'hAAAA_AAAA,
      LimitSeconds - 32'd1,     // last in-range second
      LimitSeconds,             // first out-of-range second
      32'd4107542400,           // 2100-02-29 under the four-year rule
      32'd4133980799,           // 2100-12-31 23:59:59
      32'd86399,                // 23:59:59 on day one
      32'd1234567890
    };
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    utc_seconds_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_word(directed[i]);
    wait_drained();

    for (int unsigned n = 0; n < 3 * WordsPerPhase; n++) begin
      send_word(pick_seconds());
      if (n == WordsPerPhase / 2) begin
        wait_drained();
      end else if (n < WordsPerPhase) begin
        idle_gap(16);
      end else if (n < 2 * WordsPerPhase) begin
        idle_gap(47);
      end
    end

    start_i <= 1'b0;
    while (dates_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
